>>> hdl/hrcs_pkg.sv
// ----------------------------------------------------------------------------
// hrcs_pkg: shared types and constants for the hot row coverage select block
// Item and result layouts, queue operation format, widths and register codes.
// ----------------------------------------------------------------------------
package hrcs_pkg;

    localparam int MAX_ROWS  = 4096;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int CNT_W     = 32;
    localparam int TOT_W     = 48;
    localparam int FRAC_W    = 17;
    localparam int RIU_W     = 13;
    localparam int WIDX_W    = 6;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [FRAC_W-1:0] THRESH_RESET = FRAC_W'(58982);
    localparam logic [RIU_W-1:0]  ROWS_RESET   = RIU_W'(4096);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_FRAC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE    = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [ROW_W-1:0] row_id;
        logic             query_end;
    } item_t;

    typedef struct packed {
        logic [63:0]       flag_word;
        logic [WIDX_W-1:0] word_index;
        logic [RIU_W-1:0]  hot_count;
        logic [TOT_W-1:0]  total_freq;
        logic              last;
    } result_t;

    typedef enum logic {
        OP_REF     = 1'b0,
        OP_COMPUTE = 1'b1
    } op_kind_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [ROW_W-1:0] row;
        logic             qend;
    } op_t;

    typedef struct packed {
        logic              empty;
        logic [QPTR_W:0]   count;
    } queue_status_t;

endpackage

>>> hdl/hot_row_coverage_select.sv
// ----------------------------------------------------------------------------
// hot_row_coverage_select: per-row query coverage and hot row bitmap
// After reset the block clears its row memories with busy high. A row
// reference then passes through the row engine as a memory read, then an
// update, with a 4-entry queue in front so start can be taken while the
// engine works. A compute runs a multiply in three 16-bit chunks, up to 32
// search sweeps over the count memory, one counting sweep and one emit sweep;
// a result word is strobed as each group of 64 rows in use completes during
// the emit sweep, and results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module hot_row_coverage_select (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  hrcs_pkg::item_t                   item,
    input  logic                              cfg_we,
    input  logic [hrcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hrcs_pkg::CFG_W-1:0]        cfg_data,
    output logic                              result_valid,
    output hrcs_pkg::result_t                 result
);
    import hrcs_pkg::*;

    logic [FRAC_W-1:0] thresh_reg, thresh_next;
    logic [RIU_W-1:0]  rows_reg, rows_next;
    logic              clearing, push, pop;
    op_t               op, head;
    queue_status_t     qstat;

    always_comb
    begin
        thresh_next = thresh_reg;
        rows_next   = rows_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD_FRAC: thresh_next = FRAC_W'(cfg_data);
                CFG_ROWS_IN_USE:    rows_next   = RIU_W'(cfg_data);
                default:            thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            rows_reg   <= ROWS_RESET;
        end
        else
        begin
            thresh_reg <= thresh_next;
            rows_reg   <= rows_next;
        end
    end

    hrcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .clearing (clearing),
        .qstat    (qstat),
        .push     (push),
        .op       (op)
    );

    hrcs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .op    (op),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    hrcs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .qstat          (qstat),
        .pop            (pop),
        .threshold_frac (thresh_reg),
        .rows_in_use    (rows_reg),
        .clearing       (clearing),
        .result_valid   (result_valid),
        .result         (result)
    );

endmodule

>>> hdl/hrcs_front.sv
// ----------------------------------------------------------------------------
// hrcs_front: item intake
// Accepts items, classifies them into queue operations and holds off intake
// while the queue has no room or the row stores are being cleared.
// ----------------------------------------------------------------------------
module hrcs_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  hrcs_pkg::item_t        item,
    input  logic                   clearing,
    input  hrcs_pkg::queue_status_t qstat,
    output logic                   push,
    output hrcs_pkg::op_t          op
);
    import hrcs_pkg::*;

    logic          vld_reg, vld_next;
    op_t           op_reg, op_next;
    logic          accept;
    logic [QPTR_W+1:0] fill;

    assign fill   = (QPTR_W+2)'(qstat.count) + (QPTR_W+2)'(vld_reg);
    assign busy   = clearing || (fill >= (QPTR_W+2)'(QDEPTH));
    assign accept = start && !busy;

    always_comb
    begin
        vld_next = accept;
        op_next  = op_reg;
        if (accept)
        begin
            if (item.cmd)
            begin
                op_next.kind = OP_COMPUTE;
                op_next.row  = '0;
                op_next.qend = 1'b0;
            end
            else
            begin
                op_next.kind = OP_REF;
                op_next.row  = item.row_id;
                op_next.qend = item.query_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    assign push = vld_reg;
    assign op   = op_reg;

endmodule

>>> hdl/hrcs_queue.sv
// ----------------------------------------------------------------------------
// hrcs_queue: operation queue
// Short FIFO between intake and the row engine.
// ----------------------------------------------------------------------------
module hrcs_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  hrcs_pkg::op_t           op,
    input  logic                    pop,
    output hrcs_pkg::op_t           head,
    output hrcs_pkg::queue_status_t qstat
);
    import hrcs_pkg::*;

    op_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= op;
    end

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.count = count_reg;

endmodule

>>> hdl/hrcs_back.sv
// ----------------------------------------------------------------------------
// hrcs_back: row engine
// Holds the per-row count and query tag memories, applies row references,
// and on compute finds the coverage cutoff by a binary search over count
// values, counts the hot rows and streams out the flag bitmap, clearing the counts.
// ----------------------------------------------------------------------------
module hrcs_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hrcs_pkg::op_t                   head,
    input  hrcs_pkg::queue_status_t         qstat,
    output logic                            pop,
    input  logic [hrcs_pkg::FRAC_W-1:0]     threshold_frac,
    input  logic [hrcs_pkg::RIU_W-1:0]      rows_in_use,
    output logic                            clearing,
    output logic                            result_valid,
    output hrcs_pkg::result_t               result
);
    import hrcs_pkg::*;

    localparam int SUM_W = CNT_W + ROW_W + 1;
    localparam int LIM_W = TOT_W + FRAC_W - 16;
    localparam int ACC_W = TOT_W + FRAC_W;
    localparam int SRC_W = CNT_W + 1;
    localparam int WRD_W = WIDX_W + 1;

    typedef enum logic [6:0] {
        ST_CLR  = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_UPD  = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_SRCH = 7'b0010000,
        ST_CNT  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [ROW_W:0]     sw_cnt_reg, sw_cnt_next;
    logic               p_vld_reg, p_vld_next;
    logic [ROW_W-1:0]   p_row_reg;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               qend_reg, qend_next;
    logic [CNT_W-1:0]   qnum_reg, qnum_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [1:0]         mul_k_reg, mul_k_next;
    logic [SRC_W-1:0]   lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [SUM_W-1:0]   ssum_reg, ssum_next, s_hi_reg, s_hi_next;
    logic [SUM_W:0]     run_reg, run_next;
    logic [RIU_W-1:0]   hot_reg, hot_next;
    logic [63:0]        word_reg, word_next;
    logic               rvalid_reg, rvalid_next;
    result_t            result_reg, result_next;

    logic [CNT_W-1:0]   cnt_mem [MAX_ROWS];
    logic [CNT_W-1:0]   tag_mem [MAX_ROWS];
    logic [CNT_W-1:0]   cnt_rd_reg, tag_rd_reg;
    logic [ROW_W-1:0]   rd_addr;
    logic               cnt_we, tag_we;
    logic [ROW_W-1:0]   cnt_wa, tag_wa;
    logic [CNT_W-1:0]   cnt_wd, tag_wd;

    logic               sweeping, issue, sweep_end;
    logic [LIM_W-1:0]   limit;
    logic [15:0]        chunk;
    logic [FRAC_W+15:0] prod;
    logic [SRC_W-1:0]   cm1;
    logic               ge, eq, fits, eq_hot, hot, flag_bit;
    logic [SUM_W+1:0]   run_try;
    logic [SUM_W-1:0]   ssum_fin;
    logic [SRC_W-1:0]   lo_n, hi_n;
    logic [SUM_W-1:0]   s_hi_n;
    logic [RIU_W-1:0]   rows_eff;
    logic [WRD_W-1:0]   words;
    logic [CNT_W-1:0]   qnum_inc;

    assign sweeping  = (state_reg == ST_CLR) || (state_reg == ST_SRCH) ||
                       (state_reg == ST_CNT) || (state_reg == ST_EMIT);
    assign issue     = sweeping && !sw_cnt_reg[ROW_W];
    assign sweep_end = p_vld_reg && (p_row_reg == ROW_W'(MAX_ROWS - 1));
    assign rd_addr   = (state_reg == ST_IDLE) ? head.row : sw_cnt_reg[ROW_W-1:0];
    assign limit     = acc_reg[ACC_W-1:16];

    assign chunk = 16'(total_reg >> {mul_k_reg, 4'b0000});
    assign prod  = chunk * threshold_frac;

    assign cm1     = hi_reg - SRC_W'(1);
    assign ge      = {1'b0, cnt_rd_reg} >= hi_reg;
    assign eq      = (hi_reg != SRC_W'(1)) && ({1'b0, cnt_rd_reg} == cm1);
    assign run_try = (SUM_W+2)'(run_reg) + (SUM_W+2)'(cm1);
    assign fits    = (LIM_W)'(run_try) <= limit;
    assign eq_hot  = eq && fits;
    assign hot     = ge || eq_hot;

    always_comb
    begin
        if (rows_in_use == '0)
            rows_eff = RIU_W'(1);
        else if (rows_in_use > RIU_W'(MAX_ROWS))
            rows_eff = RIU_W'(MAX_ROWS);
        else
            rows_eff = rows_in_use;
    end

    assign words    = WRD_W'((rows_eff + RIU_W'(63)) >> 6);
    assign flag_bit = !hot && ({1'b0, p_row_reg} < rows_eff);

    assign ssum_fin = ({1'b0, cnt_rd_reg} >= mid_reg) ?
                      ssum_reg + SUM_W'(cnt_rd_reg) : ssum_reg;
    assign qnum_inc = (qnum_reg == '1) ? CNT_W'(1) : qnum_reg + CNT_W'(1);

    always_comb
    begin
        if ((LIM_W)'(ssum_fin) <= limit)
        begin
            lo_n   = lo_reg;
            hi_n   = mid_reg;
            s_hi_n = ssum_fin;
        end
        else
        begin
            lo_n   = mid_reg + SRC_W'(1);
            hi_n   = hi_reg;
            s_hi_n = s_hi_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sw_cnt_next = issue ? sw_cnt_reg + (ROW_W+1)'(1) : sw_cnt_reg;
        p_vld_next  = issue;
        row_next    = row_reg;
        qend_next   = qend_reg;
        qnum_next   = qnum_reg;
        total_next  = total_reg;
        acc_next    = acc_reg;
        mul_k_next  = mul_k_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        ssum_next   = ssum_reg;
        s_hi_next   = s_hi_reg;
        run_next    = run_reg;
        hot_next    = hot_reg;
        word_next   = word_reg;
        rvalid_next = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;
        cnt_we      = 1'b0;
        cnt_wa      = row_reg;
        cnt_wd      = '0;
        tag_we      = 1'b0;
        tag_wa      = row_reg;
        tag_wd      = qnum_reg;

        unique case (state_reg)
            ST_CLR:
            begin
                cnt_we = issue;
                cnt_wa = sw_cnt_reg[ROW_W-1:0];
                tag_we = issue;
                tag_wa = sw_cnt_reg[ROW_W-1:0];
                tag_wd = '0;
                if (sw_cnt_reg[ROW_W-1:0] == ROW_W'(MAX_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                    p_vld_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop = 1'b1;
                    if (head.kind == OP_COMPUTE)
                    begin
                        acc_next   = '0;
                        mul_k_next = '0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        row_next   = head.row;
                        qend_next  = head.qend;
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                if (tag_rd_reg != qnum_reg)
                begin
                    tag_we = 1'b1;
                    if (cnt_rd_reg != '1)
                    begin
                        cnt_we = 1'b1;
                        cnt_wd = cnt_rd_reg + CNT_W'(1);
                        if (total_reg != '1)
                            total_next = total_reg + TOT_W'(1);
                    end
                end
                if (qend_reg)
                    qnum_next = qnum_inc;
                state_next = ST_IDLE;
            end
            ST_MUL:
            begin
                acc_next   = acc_reg + (ACC_W'(prod) << {mul_k_reg, 4'b0000});
                mul_k_next = mul_k_reg + 2'd1;
                if (mul_k_reg == 2'd2)
                begin
                    lo_next     = SRC_W'(1);
                    hi_next     = SRC_W'(1) << CNT_W;
                    mid_next    = SRC_W'(1) << (CNT_W - 1);
                    s_hi_next   = '0;
                    ssum_next   = '0;
                    sw_cnt_next = '0;
                    state_next  = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (p_vld_reg)
                    ssum_next = ssum_fin;
                if (sweep_end)
                begin
                    lo_next     = lo_n;
                    hi_next     = hi_n;
                    s_hi_next   = s_hi_n;
                    ssum_next   = '0;
                    sw_cnt_next = '0;
                    mid_next    = SRC_W'(({1'b0, lo_n} + {1'b0, hi_n}) >> 1);
                    if (lo_n == hi_n)
                    begin
                        run_next   = (SUM_W+1)'(s_hi_n);
                        hot_next   = '0;
                        state_next = ST_CNT;
                    end
                end
            end
            ST_CNT:
            begin
                if (p_vld_reg)
                begin
                    if (hot)
                        hot_next = hot_reg + RIU_W'(1);
                    if (eq_hot)
                        run_next = (SUM_W+1)'(run_try);
                end
                if (sweep_end)
                begin
                    run_next    = (SUM_W+1)'(s_hi_reg);
                    word_next   = '0;
                    sw_cnt_next = '0;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (p_vld_reg)
                begin
                    cnt_we    = 1'b1;
                    cnt_wa    = p_row_reg;
                    word_next = {word_reg[62:0], flag_bit};
                    if (eq_hot)
                        run_next = (SUM_W+1)'(run_try);
                    if ((p_row_reg[5:0] == 6'd63) &&
                        ({1'b0, p_row_reg[ROW_W-1:6]} < words))
                    begin
                        rvalid_next            = 1'b1;
                        result_next.flag_word  = {word_reg[62:0], flag_bit};
                        result_next.word_index = WIDX_W'(p_row_reg[ROW_W-1:6]);
                        result_next.hot_count  = hot_reg;
                        result_next.total_freq = total_reg;
                        result_next.last       = ({1'b0, p_row_reg[ROW_W-1:6]} ==
                                                  words - WRD_W'(1));
                    end
                end
                if (sweep_end)
                begin
                    total_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            sw_cnt_reg <= '0;
            p_vld_reg  <= 1'b0;
            qnum_reg   <= CNT_W'(1);
            total_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sw_cnt_reg <= sw_cnt_next;
            p_vld_reg  <= p_vld_next;
            qnum_reg   <= qnum_next;
            total_reg  <= total_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_row_reg  <= sw_cnt_reg[ROW_W-1:0];
        row_reg    <= row_next;
        qend_reg   <= qend_next;
        acc_reg    <= acc_next;
        mul_k_reg  <= mul_k_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        ssum_reg   <= ssum_next;
        s_hi_reg   <= s_hi_next;
        run_reg    <= run_next;
        hot_reg    <= hot_next;
        word_reg   <= word_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_wa] <= cnt_wd;
        cnt_rd_reg <= cnt_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[tag_wa] <= tag_wd;
        tag_rd_reg <= tag_mem[rd_addr];
    end

    assign clearing     = (state_reg == ST_CLR);
    assign result_valid = rvalid_reg;
    assign result       = result_reg;

endmodule

>>> hdl/hrcs_checker.sv
// ----------------------------------------------------------------------------
// hrcs_checker: port-level checks
// Result word spacing, bitmap ordering and hot count range.
// ----------------------------------------------------------------------------
module hrcs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  hrcs_pkg::item_t                   item,
    input  logic                              cfg_we,
    input  logic [hrcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hrcs_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              result_valid,
    input  hrcs_pkg::result_t                 result
);
    import hrcs_pkg::*;

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("strobe right after last word");

    a_word_next: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> ##64 (result_valid &&
            result.word_index == $past(result.word_index, 64) + WIDX_W'(1)))
        else $error("next bitmap word missing or out of order");

    a_same_hot: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.word_index != '0) |->
            (result.hot_count == $past(result.hot_count, 64) &&
             result.total_freq == $past(result.total_freq, 64)))
        else $error("summary fields changed within one bitmap");

    a_hot_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.hot_count <= RIU_W'(MAX_ROWS)))
        else $error("hot count out of range");

endmodule

bind hot_row_coverage_select hrcs_checker u_hrcs_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for hot_row_coverage_select
// Streams row references grouped into queries and compute commands into the
// block, predicts the hot row bitmap words and checks every strobed word.
// Register writes happen only while the block is idle, across several settings.
// ----------------------------------------------------------------------------
module tb_top;
    import hrcs_pkg::*;

    localparam int QUIET_CYCLES = 4200;
    localparam int WATCHDOG_MAX = 600000;

    typedef struct {
        bit                   is_cfg;
        item_t                it;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } pending_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    item_t                item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 result_valid;
    result_t              result;

    pending_t pending_q[$];
    result_t  bitmap_q[$];

    logic [CNT_W-1:0]  row_cnt[MAX_ROWS];
    logic [CNT_W-1:0]  row_tag[MAX_ROWS];
    logic [CNT_W-1:0]  qnum;
    logic [TOT_W-1:0]  freq_sum;
    logic [FRAC_W-1:0] thr_frac;
    logic [RIU_W-1:0]  rows_used;

    int  err_cnt;
    int  items_taken;
    int  words_seen;
    int  computes_seen;
    int  quiet;
    int  stall;
    bit  took;

    hot_row_coverage_select u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic count_reference(input item_t it);
        if (row_tag[it.row_id] != qnum)
        begin
            row_tag[it.row_id] = qnum;
            if (row_cnt[it.row_id] != '1)
            begin
                row_cnt[it.row_id]++;
                if (freq_sum != '1)
                    freq_sum++;
            end
        end
        if (it.query_end)
        begin
            qnum++;
            if (qnum == 0)
                qnum = 1;
        end
    endtask

    task automatic predict_bitmap();
        logic [65:0]      limit;
        logic [65:0]      run;
        logic [CNT_W-1:0] maxc;
        logic [63:0]      word;
        bit               hot_flag[MAX_ROWS];
        bit               stop;
        int               hot;
        int               rows;
        int               words;
        int               rr;
        result_t          res;
        maxc = 0;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            hot_flag[r] = 1'b0;
            if (row_cnt[r] > maxc)
                maxc = row_cnt[r];
        end
        limit = ({18'd0, freq_sum} * {49'd0, thr_frac}) >> 16;
        run = 0;
        hot = 0;
        stop = 0;
        for (longint c = maxc; c >= 1 && !stop; c--)
            for (int r = 0; r < MAX_ROWS && !stop; r++)
                if (row_cnt[r] == c)
                begin
                    run += c;
                    if (run > limit)
                        stop = 1;
                    else
                    begin
                        hot_flag[r] = 1'b1;
                        hot++;
                    end
                end
        rows = rows_used;
        if (rows == 0)
            rows = 1;
        if (rows > MAX_ROWS)
            rows = MAX_ROWS;
        words = (rows + 63) / 64;
        for (int w = 0; w < words; w++)
        begin
            word = '0;
            for (int b = 0; b < 64; b++)
            begin
                rr = w * 64 + b;
                if (rr < rows && !hot_flag[rr])
                    word[63 - b] = 1'b1;
            end
            res.flag_word  = word;
            res.word_index = WIDX_W'(w);
            res.hot_count  = RIU_W'(hot);
            res.total_freq = freq_sum;
            res.last       = (w + 1 == words);
            bitmap_q = {bitmap_q, res};
        end
        for (int r = 0; r < MAX_ROWS; r++)
            row_cnt[r] = '0;
        freq_sum = '0;
    endtask

    // monitor: sample accepted items, register writes and result words
    always @(posedge clk)
    begin
        result_t exp_r;
        bit      active;
        if (rst_n)
        begin
            active = 0;
            took <= start && !busy;
            if (cfg_we)
            begin
                if (cfg_index == CFG_THRESHOLD_FRAC)
                    thr_frac = cfg_data[FRAC_W-1:0];
                else
                    rows_used = cfg_data[RIU_W-1:0];
            end
            if (start && !busy)
            begin
                active = 1;
                items_taken++;
                if (item.cmd == OP_COMPUTE)
                begin
                    computes_seen++;
                    predict_bitmap();
                end
                else
                    count_reference(item);
            end
            if (result_valid)
            begin
                active = 1;
                words_seen++;
                if (bitmap_q.size() == 0)
                begin
                    $error("unexpected result word index %0d", result.word_index);
                    err_cnt++;
                end
                else
                begin
                    exp_r = bitmap_q.pop_front();
                    if (result.flag_word !== exp_r.flag_word)
                    begin
                        $error("flag_word exp %h got %h", exp_r.flag_word, result.flag_word);
                        err_cnt++;
                    end
                    if (result.word_index !== exp_r.word_index)
                    begin
                        $error("word_index exp %0d got %0d", exp_r.word_index,
                               result.word_index);
                        err_cnt++;
                    end
                    if (result.hot_count !== exp_r.hot_count)
                    begin
                        $error("hot_count exp %0d got %0d", exp_r.hot_count, result.hot_count);
                        err_cnt++;
                    end
                    if (result.total_freq !== exp_r.total_freq)
                    begin
                        $error("total_freq exp %0d got %0d", exp_r.total_freq,
                               result.total_freq);
                        err_cnt++;
                    end
                    if (result.last !== exp_r.last)
                    begin
                        $error("last exp %0d got %0d", exp_r.last, result.last);
                        err_cnt++;
                    end
                end
            end
            quiet = active ? 0 : quiet + 1;
            stall = active ? 0 : stall + 1;
            if (stall >= WATCHDOG_MAX)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // driver: feed items and register writes at the falling edge
    always @(negedge clk)
    begin
        bit                   n_start;
        bit                   n_we;
        item_t                n_item;
        logic [CFG_IDX_W-1:0] n_idx;
        logic [CFG_W-1:0]     n_data;
        bit                   idle_ok;
        n_start = start;
        n_we    = 1'b0;
        n_item  = item;
        n_idx   = cfg_index;
        n_data  = cfg_data;
        if (rst_n)
        begin
            if (start && took)
            begin
                void'(pending_q.pop_front());
                n_start = 1'b0;
            end
            idle_ok = (items_taken >= 110 && items_taken < 170) ||
                      ($urandom_range(99) >= 22);
            if (!n_start && pending_q.size() > 0)
            begin
                if (pending_q[0].is_cfg)
                begin
                    if (!start && bitmap_q.size() == 0 && !busy && quiet >= QUIET_CYCLES)
                    begin
                        n_we   = 1'b1;
                        n_idx  = pending_q[0].idx;
                        n_data = pending_q[0].data;
                        void'(pending_q.pop_front());
                    end
                end
                else if (idle_ok)
                begin
                    n_start = 1'b1;
                    n_item  = pending_q[0].it;
                end
            end
        end
        start     <= n_start;
        item      <= n_item;
        cfg_we    <= n_we;
        cfg_index <= n_idx;
        cfg_data  <= n_data;
    end

    task automatic add_ref(input int row, input bit qend);
        pending_t p;
        p.is_cfg = 0;
        p.it.cmd = OP_REF;
        p.it.row_id = ROW_W'(row);
        p.it.query_end = qend;
        p.idx = '0;
        p.data = '0;
        pending_q = {pending_q, p};
    endtask

    task automatic add_compute();
        pending_t p;
        p.is_cfg = 0;
        p.it.cmd = OP_COMPUTE;
        p.it.row_id = ROW_W'($urandom);
        p.it.query_end = 1'($urandom_range(1));
        p.idx = '0;
        p.data = '0;
        pending_q = {pending_q, p};
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
        pending_t p;
        p.is_cfg = 1;
        p.it = '0;
        p.idx = idx;
        p.data = CFG_W'(data);
        pending_q = {pending_q, p};
    endtask

    task automatic add_queries(input int n_refs);
        int left;
        int len;
        int pool;
        int row;
        left = n_refs;
        while (left > 0)
        begin
            len = $urandom_range(6, 1);
            pool = $urandom_range(3);
            for (int k = 0; k < len && left > 0; k++)
            begin
                row = (pool == 0) ? $urandom_range(4095) :
                      (pool == 1) ? $urandom_range(15) : $urandom_range(200);
                if ($urandom_range(9) == 0)
                    row = 4095 - $urandom_range(3);
                left--;
                add_ref(row, (k == len - 1) ? ($urandom_range(19) != 0)
                                             : ($urandom_range(29) == 0));
            end
        end
    endtask

    initial
    begin
        int cycles_end;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        err_cnt = 0;
        items_taken = 0;
        words_seen = 0;
        computes_seen = 0;
        quiet = 0;
        stall = 0;
        took = 0;
        qnum = 1;
        freq_sum = '0;
        thr_frac = THRESH_RESET;
        rows_used = ROWS_RESET;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            row_cnt[r] = '0;
            row_tag[r] = '0;
        end

        // directed: edge rows, repeats in a query, ties, open query at compute
        add_compute();
        add_ref(0, 0);
        add_ref(0, 0);
        add_ref(4095, 1);
        add_ref(4095, 0);
        add_ref(63, 0);
        add_ref(64, 1);
        add_ref(63, 1);
        add_ref(64, 1);
        add_ref(2730, 0);
        add_ref(1365, 1);
        add_ref(0, 0);
        add_compute();
        add_ref(0, 1);
        add_ref(5, 1);
        add_cfg(CFG_THRESHOLD_FRAC, 0);
        add_cfg(CFG_ROWS_IN_USE, 1);
        add_compute();

        add_cfg(CFG_THRESHOLD_FRAC, 65536);
        add_cfg(CFG_ROWS_IN_USE, 100);
        add_queries(70);
        add_compute();

        add_cfg(CFG_THRESHOLD_FRAC, $urandom_range(65535));
        add_cfg(CFG_ROWS_IN_USE, 0);
        add_queries(60);
        add_compute();

        add_cfg(CFG_THRESHOLD_FRAC, 131071);
        add_cfg(CFG_ROWS_IN_USE, 8191);
        add_queries(60);
        add_compute();

        add_cfg(CFG_THRESHOLD_FRAC, 32768 + $urandom_range(32767));
        add_cfg(CFG_ROWS_IN_USE, $urandom_range(4096, 1));
        add_queries(60);
        add_compute();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_q.size() == 0 && bitmap_q.size() == 0);
        cycles_end = 0;
        while (cycles_end < 200)
        begin
            @(posedge clk);
            cycles_end++;
        end
        $display("run covered %0d items, %0d computes, %0d bitmap words checked",
                 items_taken, computes_seen, words_seen);
        if (err_cnt == 0 && bitmap_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
hdl/hrcs_pkg.sv
hdl/hrcs_front.sv
hdl/hrcs_queue.sv
hdl/hrcs_back.sv
hdl/hot_row_coverage_select.sv
hdl/hrcs_checker.sv
dv/tb_top.sv
